// File: hdl/deq_pkg.sv
// Shared types, constants and index helpers for the double-ended queue.
package deq_pkg;

	localparam int DEPTH        = 64;
	localparam int DATA_WIDTH   = 32;
	localparam int OP_WIDTH     = 3;
	localparam int VALUE_WIDTH  = 32;
	localparam int STATUS_WIDTH = 3;
	localparam int IDX_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W        = $clog2(DEPTH + 1);

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [DATA_WIDTH-1:0] word_t;

	typedef enum logic [OP_WIDTH-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_LIST_ALL   = 3'd4
	} op_t;

	typedef enum logic [STATUS_WIDTH-1:0] {
		RS_PUSHED       = 3'd0,
		RS_FULL_DROPPED = 3'd1,
		RS_POPPED       = 3'd2,
		RS_POPPED_LAST  = 3'd3,
		RS_POP_EMPTY    = 3'd4,
		RS_LISTED       = 3'd5,
		RS_LIST_EMPTY   = 3'd6
	} rstatus_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_LIST
	} state_t;

	typedef enum logic [2:0] {
		DP_NONE,
		DP_PUSH_FRONT,
		DP_PUSH_BACK,
		DP_POP_FRONT,
		DP_POP_BACK,
		DP_LIST_FIRST,
		DP_LIST_NEXT
	} dp_op_t;

	typedef struct packed {
		dp_op_t   op;
		logic     out_load;
		logic     out_use_mem;
		logic     out_last;
		rstatus_t out_status;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic count_zero;
		logic list_end;
		logic out_free;
	} dp_stat_t;

	// head + offset modulo DEPTH; both operands stay below DEPTH
	function automatic idx_t wrap_add(idx_t head, cnt_t offset);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(offset);
		if (sum >= (CNT_W + 1)'(DEPTH))
			sum = sum - (CNT_W + 1)'(DEPTH);
		return sum[IDX_W-1:0];
	endfunction

	function automatic idx_t wrap_dec(idx_t head);
		return (head == '0) ? IDX_W'(DEPTH - 1) : head - 1'b1;
	endfunction

endpackage

// File: hdl/deq_ctrl.sv
// Controller state machine: decodes operations and sequences pops and listing.
module deq_ctrl import deq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                op_valid,
	output logic                op_ready,
	input  logic [OP_WIDTH-1:0] operation,
	input  dp_stat_t            stat,
	output dp_cmd_t             cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d         = state_q;
		op_ready        = 1'b0;
		cmd.op          = DP_NONE;
		cmd.out_load    = 1'b0;
		cmd.out_use_mem = 1'b0;
		cmd.out_last    = 1'b1;
		cmd.out_status  = RS_PUSHED;
		case (state_q)
			ST_IDLE: begin
				op_ready = stat.out_free;
				if (op_valid && stat.out_free) begin
					case (op_t'(operation))
						OP_PUSH_FRONT, OP_PUSH_BACK: begin
							cmd.out_load = 1'b1;
							if (stat.full) begin
								cmd.out_status = RS_FULL_DROPPED;
							end else begin
								cmd.out_status = RS_PUSHED;
								cmd.op = (op_t'(operation) == OP_PUSH_FRONT) ?
									DP_PUSH_FRONT : DP_PUSH_BACK;
							end
						end
						OP_POP_FRONT, OP_POP_BACK: begin
							if (stat.empty) begin
								cmd.out_load   = 1'b1;
								cmd.out_status = RS_POP_EMPTY;
							end else begin
								cmd.op = (op_t'(operation) == OP_POP_FRONT) ?
									DP_POP_FRONT : DP_POP_BACK;
								state_d = ST_POP;
							end
						end
						OP_LIST_ALL: begin
							if (stat.empty) begin
								cmd.out_load   = 1'b1;
								cmd.out_status = RS_LIST_EMPTY;
							end else begin
								cmd.op  = DP_LIST_FIRST;
								state_d = ST_LIST;
							end
						end
						default: begin
							// unknown code: take the transaction, no result
						end
					endcase
				end
			end
			ST_POP: begin
				// read data is ready; the output slot was freed at accept
				cmd.out_load    = 1'b1;
				cmd.out_use_mem = 1'b1;
				cmd.out_status  = stat.count_zero ? RS_POPPED_LAST : RS_POPPED;
				state_d         = ST_IDLE;
			end
			ST_LIST: begin
				if (stat.out_free) begin
					cmd.out_load    = 1'b1;
					cmd.out_use_mem = 1'b1;
					cmd.out_status  = RS_LISTED;
					cmd.out_last    = stat.list_end;
					if (stat.list_end)
						state_d = ST_IDLE;
					else
						cmd.op = DP_LIST_NEXT;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: hdl/deq_dpath.sv
// Datapath: ring store, head and count registers, list index and result register.
module deq_dpath import deq_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic signed [VALUE_WIDTH-1:0]  push_value,
	input  dp_cmd_t                        cmd,
	output dp_stat_t                       stat,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic signed [VALUE_WIDTH-1:0]  result_value,
	output logic [STATUS_WIDTH-1:0]        status,
	output logic                           last_result
);

	word_t mem [DEPTH];
	word_t rd_data_q;
	idx_t  head_q;
	cnt_t  count_q;
	cnt_t  list_idx_q;
	logic  out_valid_q;
	logic signed [VALUE_WIDTH-1:0] out_value_q;
	logic [STATUS_WIDTH-1:0]       out_status_q;
	logic                          out_last_q;

	cnt_t  offset;
	idx_t  slot;
	idx_t  head_dec;
	word_t word_in;
	logic  wr_en, rd_en;
	idx_t  wr_addr, rd_addr;

	assign word_in  = DATA_WIDTH'(push_value);
	assign head_dec = wrap_dec(head_q);

	// one shared ring adder for the back slot, pop-back slot and list walk
	always_comb begin
		case (cmd.op)
			DP_PUSH_BACK: offset = count_q;
			DP_POP_BACK:  offset = count_q - 1'b1;
			DP_LIST_NEXT: offset = list_idx_q;
			default:      offset = '0;
		endcase
	end
	assign slot = wrap_add(head_q, offset);

	always_comb begin
		wr_en   = (cmd.op == DP_PUSH_FRONT) || (cmd.op == DP_PUSH_BACK);
		wr_addr = (cmd.op == DP_PUSH_FRONT) ? head_dec : slot;
		rd_en   = (cmd.op == DP_POP_FRONT) || (cmd.op == DP_POP_BACK) ||
			(cmd.op == DP_LIST_FIRST) || (cmd.op == DP_LIST_NEXT);
		rd_addr = slot;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= word_in;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			count_q    <= '0;
			list_idx_q <= '0;
		end else begin
			case (cmd.op)
				DP_PUSH_FRONT: begin
					head_q  <= head_dec;
					count_q <= count_q + 1'b1;
				end
				DP_PUSH_BACK: count_q <= count_q + 1'b1;
				DP_POP_FRONT: begin
					head_q  <= wrap_add(head_q, CNT_W'(1));
					count_q <= count_q - 1'b1;
				end
				DP_POP_BACK:   count_q <= count_q - 1'b1;
				DP_LIST_FIRST: list_idx_q <= CNT_W'(1);
				DP_LIST_NEXT:  list_idx_q <= list_idx_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (res_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_value_q  <= cmd.out_use_mem ? VALUE_WIDTH'($signed(rd_data_q)) : '0;
			out_status_q <= cmd.out_status;
			out_last_q   <= cmd.out_last;
		end
	end

	always_comb begin
		stat.full       = (count_q == CNT_W'(DEPTH));
		stat.empty      = (count_q == '0);
		stat.count_zero = (count_q == '0);
		stat.list_end   = (list_idx_q == count_q);
		stat.out_free   = !out_valid_q || res_ready;
	end

	assign res_valid    = out_valid_q;
	assign result_value = out_value_q;
	assign status       = out_status_q;
	assign last_result  = out_last_q;

endmodule

// File: hdl/double_ended_queue.sv
// Top level of the double-ended queue: controller plus datapath.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------
//   op      | op_valid / op_ready | operation, push_value
//   res     | res_valid/res_ready | result_value, status, last_result
//
// Push, failed pop and empty list: the result is registered and appears in the next cycle.
// Pop: the store read is registered, then the result register loads from it in ST_POP.
// List of N entries: N results, one store read a cycle unless the result stalls, op_ready low meanwhile.
// A stalled result holds the result register and the list walk; op_ready drops.
// Reset clears head and count at once; the store contents are not cleared.
module double_ended_queue import deq_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          op_valid,
	output logic                          op_ready,
	input  logic [OP_WIDTH-1:0]           operation,
	input  logic signed [VALUE_WIDTH-1:0] push_value,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic signed [VALUE_WIDTH-1:0] result_value,
	output logic [STATUS_WIDTH-1:0]       status,
	output logic                          last_result
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.operation (operation),
		.stat      (stat),
		.cmd       (cmd)
	);

	deq_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_value   (push_value),
		.cmd          (cmd),
		.stat         (stat),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.result_value (result_value),
		.status       (status),
		.last_result  (last_result)
	);

endmodule

// File: hdl/deq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
module deq_checker import deq_pkg::*; (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          op_valid,
	input logic                          op_ready,
	input logic [OP_WIDTH-1:0]           operation,
	input logic signed [VALUE_WIDTH-1:0] push_value,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic signed [VALUE_WIDTH-1:0] result_value,
	input logic [STATUS_WIDTH-1:0]       status,
	input logic                          last_result
);

	// a waiting operation holds its payload
	a_op_hold: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && !op_ready |=> op_valid && $stable(operation) && $stable(push_value))
		else $error("operation changed while waiting");

	// a stalled result holds its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(result_value) &&
		$stable(status) && $stable(last_result))
		else $error("result changed while stalled");

	// results that carry no word report zero
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == RS_PUSHED || status == RS_FULL_DROPPED ||
		status == RS_POP_EMPTY || status == RS_LIST_EMPTY) |-> result_value == '0)
		else $error("nonzero value on a result without a word");

	// only listing spans several results
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != RS_LISTED |-> last_result)
		else $error("single-result transaction without last mark");

	// input stays blocked while a list is still streaming
	a_list_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == RS_LISTED && !last_result |-> !op_ready)
		else $error("op accepted in the middle of a list");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

// File: bench/tb_double_ended_queue.sv
// Self-checking testbench for the double-ended queue: random traffic, scoreboard, watchdog.
module tb_double_ended_queue;
	import deq_pkg::*;

	localparam logic [OP_WIDTH-1:0] OP_RESERVED_FIRST = 3'd5;
	localparam logic [OP_WIDTH-1:0] OP_RESERVED_LAST  = 3'd7;
	localparam int RANDOM_ITEMS  = 450;
	localparam int QUIET_LIMIT   = 2000;
	localparam int LONG_HOLD     = 300;
	localparam int HOLD_AT       = 150;
	localparam int PRINT_LIMIT   = 40;

	typedef struct {
		logic [OP_WIDTH-1:0]           op;
		logic signed [VALUE_WIDTH-1:0] value;
	} deq_item_t;

	typedef struct {
		logic signed [VALUE_WIDTH-1:0] value;
		rstatus_t                      status;
		logic                          last;
	} deq_result_t;

	typedef enum int {SEQ_FILL, SEQ_GROW, SEQ_DRAIN, SEQ_LIST, SEQ_MIXED, SEQ_NOISE} seq_kind_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          op_valid = 1'b0;
	logic                          op_ready;
	logic [OP_WIDTH-1:0]           operation = '0;
	logic signed [VALUE_WIDTH-1:0] push_value = '0;
	logic                          res_valid;
	logic                          res_ready = 1'b0;
	logic signed [VALUE_WIDTH-1:0] result_value;
	logic [STATUS_WIDTH-1:0]       status;
	logic                          last_result;

	double_ended_queue DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid     (op_valid),
		.op_ready     (op_ready),
		.operation    (operation),
		.push_value   (push_value),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.result_value (result_value),
		.status       (status),
		.last_result  (last_result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow of the queue contents
	word_t       model_words [DEPTH];
	int unsigned model_front = 0;
	int unsigned model_count = 0;

	deq_item_t   op_backlog[$];
	deq_result_t awaited_results[$];

	logic [31:0] cycle_no = '0;
	int unsigned quiet_cycles = 0;
	int unsigned mismatches = 0;
	int unsigned results_checked = 0;
	int unsigned pushes_seen = 0, pops_seen = 0, lists_seen = 0, ignored_seen = 0;
	int unsigned full_drops = 0, empty_pops = 0, listed_words = 0;
	int unsigned gen_count = 0;
	int unsigned random_items = 0;

	function automatic void queue_result(word_t w, rstatus_t st, logic last);
		deq_result_t r;
		r.value  = $signed(w);
		r.status = st;
		r.last   = last;
		awaited_results.insert(awaited_results.size(), r);
	endfunction

	// Update the shadow queue and record the results this transaction must produce
	function automatic void deque_apply(logic [OP_WIDTH-1:0] op,
			logic signed [VALUE_WIDTH-1:0] value);
		word_t w;
		w = word_t'(value);
		case (op)
		OP_PUSH_FRONT, OP_PUSH_BACK: begin
			pushes_seen++;
			if (model_count >= DEPTH) begin
				full_drops++;
				queue_result('0, RS_FULL_DROPPED, 1'b1);
			end else begin
				if (op == OP_PUSH_FRONT) begin
					model_front = (model_front + DEPTH - 1) % DEPTH;
					model_words[model_front] = w;
				end else begin
					model_words[(model_front + model_count) % DEPTH] = w;
				end
				model_count++;
				queue_result('0, RS_PUSHED, 1'b1);
			end
		end
		OP_POP_FRONT, OP_POP_BACK: begin
			pops_seen++;
			if (model_count == 0) begin
				empty_pops++;
				queue_result('0, RS_POP_EMPTY, 1'b1);
			end else begin
				if (op == OP_POP_FRONT) begin
					w = model_words[model_front];
					model_front = (model_front + 1) % DEPTH;
				end else begin
					w = model_words[(model_front + model_count - 1) % DEPTH];
				end
				model_count--;
				queue_result(w, (model_count == 0) ? RS_POPPED_LAST : RS_POPPED, 1'b1);
			end
		end
		OP_LIST_ALL: begin
			lists_seen++;
			if (model_count == 0)
				queue_result('0, RS_LIST_EMPTY, 1'b1);
			for (int unsigned i = 0; i < model_count; i++) begin
				listed_words++;
				queue_result(model_words[(model_front + i) % DEPTH], RS_LISTED,
					i + 1 == model_count);
			end
		end
		default: ignored_seen++;
		endcase
	endfunction

	// Mostly back-to-back, some short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [VALUE_WIDTH-1:0] pick_word();
		case ($urandom_range(0, 7))
		0: return 32'h8000_0000;
		1: return 32'h7FFF_FFFF;
		2: return 32'h0000_0000;
		3: return 32'hFFFF_FFFF;
		default: return $urandom();
		endcase
	endfunction

	// Track the fill level while building stimulus, so sequences can aim at full and empty
	function automatic void add_item(logic [OP_WIDTH-1:0] op, logic [VALUE_WIDTH-1:0] value);
		deq_item_t it;
		it.op    = op;
		it.value = value;
		op_backlog.insert(op_backlog.size(), it);
		random_items++;
		if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && gen_count < DEPTH)
			gen_count++;
		if ((op == OP_POP_FRONT || op == OP_POP_BACK) && gen_count > 0)
			gen_count--;
	endfunction

	function automatic logic [OP_WIDTH-1:0] any_push();
		return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
	endfunction

	function automatic logic [OP_WIDTH-1:0] any_pop();
		return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
	endfunction

	function automatic logic [OP_WIDTH-1:0] any_reserved();
		return OP_WIDTH'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
	endfunction

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("mismatch on result %0d: %s expected %0h got %0h",
				results_checked, what, want, got);
	endtask

	// Sender: offer items from the backlog, hold each until the transaction completes
	always @(posedge clk) begin : op_driver
		deq_item_t   nxt;
		int unsigned gap_left;
		if (arst_n) begin
			if (op_valid && op_ready)
				deque_apply(operation, push_value);
			if (!op_valid || op_ready) begin
				if (gap_left != 0) begin
					gap_left--;
					op_valid <= 1'b0;
				end else if (op_backlog.size() != 0) begin
					nxt = op_backlog[0];
					op_backlog.delete(0);
					operation  <= nxt.op;
					push_value <= nxt.value;
					op_valid   <= 1'b1;
					gap_left = (cycle_no[8:7] == 2'b00) ? 0 : pick_gap();
				end else begin
					op_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result against the oldest expectation, stall at random
	always @(posedge clk) begin : result_check
		deq_result_t want;
		logic        ready_next;
		int unsigned stall_left;
		int unsigned hold_left;
		bit          hold_done;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected result, status", '0, 32'(status));
				end else begin
					want = awaited_results[0];
					awaited_results.delete(0);
					if (result_value !== want.value)
						report_mismatch("result_value", want.value, result_value);
					if (status !== want.status)
						report_mismatch("status", 32'(want.status), 32'(status));
					if (last_result !== want.last)
						report_mismatch("last_result", 32'(want.last), 32'(last_result));
				end
				results_checked++;
				// one long hold-off so the block backs up and stalls its input
				if (results_checked == HOLD_AT && !hold_done) begin
					hold_done = 1'b1;
					hold_left = LONG_HOLD;
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				ready_next = 1'b0;
			end else begin
				ready_next = 1'b1;
				if (cycle_no[8:7] != 2'b10 && $urandom_range(0, 99) < 25)
					stall_left = pick_gap();
			end
			res_ready <= ready_next;
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_no <= cycle_no + 1;
		if (!arst_n || (op_valid && op_ready) || (res_valid && res_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
			$display("tb_double_ended_queue: FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		seq_kind_t   kind;
		int unsigned n;
		int unsigned r;

		// empty store: pops and list report empty
		add_item(OP_POP_FRONT, pick_word());
		add_item(OP_POP_BACK, pick_word());
		add_item(OP_LIST_ALL, pick_word());
		// extreme words from both ends
		add_item(OP_PUSH_FRONT, 32'h8000_0000);
		add_item(OP_PUSH_BACK, 32'h7FFF_FFFF);
		add_item(OP_PUSH_FRONT, 32'hFFFF_FFFF);
		add_item(OP_PUSH_BACK, 32'h0000_0000);
		add_item(OP_PUSH_BACK, 32'h5555_5555);
		add_item(OP_PUSH_FRONT, 32'hAAAA_AAAA);
		add_item(OP_LIST_ALL, '0);
		// drain from alternating ends; the final pop takes the only entry
		for (int i = 0; i < 3; i++) begin
			add_item(OP_POP_FRONT, pick_word());
			add_item(OP_POP_BACK, pick_word());
		end
		// unknown codes are dropped without a result
		for (int c = OP_RESERVED_FIRST; c <= OP_RESERVED_LAST; c++)
			add_item(c[OP_WIDTH-1:0], pick_word());
		add_item(OP_PUSH_BACK, 32'h0000_0001);
		add_item(OP_LIST_ALL, '0);
		add_item(OP_POP_FRONT, '0);

		// random sequences: fill to full and drain to empty first, then a mix
		for (int seq = 0; random_items < RANDOM_ITEMS; seq++) begin
			if (seq == 0)
				kind = SEQ_FILL;
			else if (seq == 1)
				kind = SEQ_DRAIN;
			else begin
				r = $urandom_range(0, 9);
				kind = (r == 0) ? SEQ_FILL : (r <= 2) ? SEQ_GROW : (r == 3) ? SEQ_DRAIN :
					(r == 4) ? SEQ_LIST : (r <= 8) ? SEQ_MIXED : SEQ_NOISE;
			end
			case (kind)
			SEQ_FILL: begin
				while (gen_count < DEPTH)
					add_item(any_push(), pick_word());
				n = $urandom_range(1, 3);
				repeat (n) add_item(any_push(), pick_word());
				if ($urandom_range(0, 1))
					add_item(OP_LIST_ALL, pick_word());
			end
			SEQ_GROW: begin
				n = $urandom_range(4, 20);
				repeat (n) add_item(any_push(), pick_word());
			end
			SEQ_DRAIN: begin
				while (gen_count > 0) begin
					add_item(any_pop(), pick_word());
					if ($urandom_range(0, 39) == 0)
						add_item(OP_LIST_ALL, pick_word());
				end
				n = $urandom_range(1, 2);
				repeat (n) add_item(any_pop(), pick_word());
			end
			SEQ_LIST: add_item(OP_LIST_ALL, pick_word());
			SEQ_MIXED: begin
				n = $urandom_range(8, 24);
				repeat (n) begin
					r = $urandom_range(0, 99);
					if (r < 42)
						add_item(any_push(), pick_word());
					else if (r < 84)
						add_item(any_pop(), pick_word());
					else if (r < 90)
						add_item(OP_LIST_ALL, pick_word());
					else
						add_item(any_reserved(), pick_word());
				end
			end
			SEQ_NOISE: begin
				n = $urandom_range(2, 6);
				repeat (n) begin
					add_item(any_reserved(), pick_word());
					if ($urandom_range(0, 1))
						add_item(any_push(), pick_word());
				end
			end
			endcase
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (op_backlog.size() != 0 || op_valid)
			@(negedge clk);
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (DEPTH + 8) @(negedge clk);

		$display("covered %0d pushes (%0d dropped on full), %0d pops (%0d on empty), %0d lists",
			pushes_seen, full_drops, pops_seen, empty_pops, lists_seen);
		$display("%0d results checked, %0d listed words, %0d unknown codes ignored, %0d mismatches",
			results_checked, listed_words, ignored_seen, mismatches);
		if (mismatches == 0)
			$display("tb_double_ended_queue: PASS");
		else
			$display("tb_double_ended_queue: FAIL");
		$finish;
	end

endmodule
